@@ rtl/core/persistent_stack_lca_engine_macros.svh @@
// Assertion macros used by the port-level checker.
`ifndef PERSISTENT_STACK_LCA_ENGINE_MACROS_SVH
`define PERSISTENT_STACK_LCA_ENGINE_MACROS_SVH

// Same-cycle implication under synchronous active-low reset.
`define PSLE_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under synchronous active-low reset.
`define PSLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication checked also while in reset.
`define PSLE_ASSERT_RST(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/psle_pkg.sv @@
// Types, codes and state encoding for the persistent stack LCA engine.
package psle_pkg;

    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_POP  = 2'd1;
    localparam logic [1:0] CMD_CMP  = 2'd2;
    localparam logic [1:0] CMD_NONE = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] version_a;
        logic [15:0] version_b;
    } psle_in_t;

    typedef struct packed {
        logic [15:0] value;
        logic [1:0]  status;
    } psle_out_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK,
        S_RDA,
        S_POPP,
        S_PDEP,
        S_PRD,
        S_PWR,
        S_RDB,
        S_DXA,
        S_DYB,
        S_LIFT,
        S_LSTP,
        S_WALK,
        S_WX,
        S_WY,
        S_FIN
    } psle_state_t;

endpackage

@@ rtl/core/persistent_stack_lca_engine.sv @@
// Persistent stack engine with binary-lifting common-depth queries.
//
//  channel | dir | handshake        | payload
//  s_      | in  | s_valid/s_ready  | s_data : psle_in_t  (cmd, version_a, version_b)
//  m_      | out | m_valid/m_ready  | m_data : psle_out_t (value, status)
//
// One beat at a time. Push does one ancestor-table read and write per level.
// Compare lifts the deeper side, then walks the levels, paced by the single
// ancestor read port. Unknown-version and full-table beats go from the check
// straight to the result; pop of an empty stack ends after the first version read.
// No clearing pass after reset; ready at once.
// A finished result waits in the output register; a new beat is taken meanwhile.
module persistent_stack_lca_engine
    import psle_pkg::*;
#(
    parameter int MAX_VERSIONS = 65536,
    parameter int LIFT_LEVELS  = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  psle_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output psle_out_t m_data
);

    localparam int AW = $clog2(MAX_VERSIONS);
    localparam int LW = $clog2(LIFT_LEVELS);
    localparam int CW = (AW > 16) ? AW : 16;
    localparam int PW = AW + LIFT_LEVELS;
    localparam int VW = 2 * AW;
    localparam int NW = AW + 1;
    localparam int AD = MAX_VERSIONS * (2 ** LW);
    localparam logic [LW-1:0] LVL_TOP = LW'(LIFT_LEVELS - 1);
    localparam logic [AW-1:0] OP_LAST = AW'(MAX_VERSIONS - 1);

    psle_state_t state_reg, state_next;
    logic [1:0]  cmd_reg, cmd_next;
    logic [15:0] va_reg, va_next, vb_reg, vb_next;
    logic [AW-1:0] opcnt_reg, opcnt_next;
    logic [AW-1:0] x_reg, x_next, y_reg, y_next;
    logic [AW-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [LW-1:0] lvl_reg, lvl_next;
    logic [NW-1:0] p_reg, p_next, ax_reg, ax_next;
    logic        side_reg, side_next;
    logic [1:0]  st_reg, st_next;
    logic [15:0] val_reg, val_next;
    logic        zero_reg;
    logic        out_valid_reg, out_valid_next;
    psle_out_t   out_data_reg, out_data_next;

    logic          vmem_we;
    logic [AW-1:0] vmem_waddr, vmem_raddr;
    logic [VW-1:0] vmem_wdata, vmem_rdata, vmem_q;
    logic          amem_we;
    logic [AW+LW-1:0] amem_waddr, amem_raddr;
    logic [NW-1:0] amem_wdata, amem_q;

    logic [AW-1:0] vq_top, vq_dep, next_node, diff;
    logic [LW-1:0] lift_lvl;
    logic [PW-1:0] pw;
    logic          walk_ok, unknown, full, out_load, push_last, p_dead;
    int            hi;

    psle_ram #(.WIDTH(VW), .DEPTH(MAX_VERSIONS)) u_vmem (
        .clk(aclk), .we(vmem_we), .waddr(vmem_waddr), .wdata(vmem_wdata),
        .raddr(vmem_raddr), .rdata(vmem_rdata)
    );

    psle_ram #(.WIDTH(NW), .DEPTH(AD)) u_amem (
        .clk(aclk), .we(amem_we), .waddr(amem_waddr), .wdata(amem_wdata),
        .raddr(amem_raddr), .rdata(amem_q)
    );

    // version 0 and node 0 are never written: read as root, depth zero
    assign vmem_q    = zero_reg ? '0 : vmem_rdata;
    assign vq_top    = vmem_q[VW-1:AW];
    assign vq_dep    = vmem_q[AW-1:0];
    assign next_node = opcnt_reg + AW'(1);
    assign diff      = (dx_reg > dy_reg) ? (dx_reg - dy_reg) : (dy_reg - dx_reg);
    assign pw        = PW'(1) << lvl_reg;
    assign walk_ok   = pw <= PW'(dx_reg);
    assign unknown   = (CW'(va_reg) > CW'(opcnt_reg)) ||
                       ((cmd_reg == CMD_CMP) && (CW'(vb_reg) > CW'(opcnt_reg)));
    assign full      = opcnt_reg == OP_LAST;
    assign out_load  = !out_valid_reg || m_ready;
    assign push_last = lvl_reg == LVL_TOP;
    assign p_dead    = p_reg[AW] || (p_reg[AW-1:0] == '0);

    always_comb begin
        hi = 0;
        for (int k = 0; k < AW; k++) begin
            if (diff[k]) begin
                hi = k;
            end
        end
        lift_lvl = (hi > LIFT_LEVELS - 1) ? LVL_TOP : LW'(hi);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_valid && s_data.cmd != CMD_NONE) state_next = S_CHK;
            S_CHK:  state_next = (unknown || full) ? S_FIN : S_RDA;
            S_RDA: begin
                unique case (cmd_reg)
                    CMD_PUSH: state_next = S_PDEP;
                    CMD_POP:  state_next = (vq_top == '0) ? S_FIN : S_POPP;
                    default:  state_next = S_RDB;
                endcase
            end
            S_POPP: state_next = S_FIN;
            S_PDEP: state_next = S_PRD;
            S_PRD: begin
                if (p_dead) begin
                    state_next = push_last ? S_IDLE : S_PRD;
                end else begin
                    state_next = S_PWR;
                end
            end
            S_PWR:  state_next = push_last ? S_IDLE : S_PRD;
            S_RDB:  state_next = S_DXA;
            S_DXA:  state_next = S_DYB;
            S_DYB:  state_next = S_LIFT;
            S_LIFT: begin
                if (dx_reg != dy_reg) begin
                    state_next = S_LSTP;
                end else begin
                    state_next = (x_reg == y_reg) ? S_FIN : S_WALK;
                end
            end
            S_LSTP: state_next = S_LIFT;
            S_WALK: state_next = walk_ok ? S_WX : S_WALK;
            S_WX:   state_next = S_WY;
            S_WY: begin
                state_next = (ax_reg == amem_q && lvl_reg == '0) ? S_FIN : S_WALK;
            end
            S_FIN:  state_next = out_load ? S_IDLE : S_FIN;
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        cmd_next = cmd_reg;  va_next = va_reg;  vb_next = vb_reg;
        opcnt_next = opcnt_reg;
        x_next = x_reg;  y_next = y_reg;  dx_next = dx_reg;  dy_next = dy_reg;
        lvl_next = lvl_reg;  p_next = p_reg;  ax_next = ax_reg;  side_next = side_reg;
        st_next = st_reg;  val_next = val_reg;
        vmem_we = 1'b0;  vmem_waddr = next_node;  vmem_wdata = '0;  vmem_raddr = '0;
        amem_we = 1'b0;  amem_waddr = '0;  amem_wdata = '0;  amem_raddr = '0;
        s_ready = 1'b0;
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_next = s_data.cmd;
                    va_next  = s_data.version_a;
                    vb_next  = s_data.version_b;
                end
            end
            S_CHK: begin
                st_next  = ST_OK;
                val_next = '0;
                if (unknown) begin
                    st_next = ST_UNKNOWN;
                end else if (full) begin
                    st_next = ST_FULL;
                end
                vmem_raddr = AW'(va_reg);
            end
            S_RDA: begin
                x_next = vq_top;
                unique case (cmd_reg)
                    CMD_PUSH: vmem_raddr = vq_top;
                    CMD_POP: begin
                        if (vq_top == '0) st_next = ST_EMPTY;
                        amem_raddr = {vq_top, LW'(0)};
                    end
                    default: vmem_raddr = AW'(vb_reg);
                endcase
            end
            S_POPP: begin
                vmem_we    = 1'b1;
                vmem_wdata = {amem_q[AW-1:0], AW'(0)};
                val_next   = 16'(x_reg);
                opcnt_next = next_node;
            end
            S_PDEP: begin
                amem_we    = 1'b1;
                amem_waddr = {next_node, LW'(0)};
                amem_wdata = {1'b0, x_reg};
                vmem_we    = 1'b1;
                vmem_wdata = {next_node, vq_dep + AW'(1)};
                p_next     = {1'b0, x_reg};
                lvl_next   = LW'(1);
            end
            S_PRD: begin
                amem_raddr = {p_reg[AW-1:0], lvl_reg - LW'(1)};
                if (p_dead) begin
                    amem_we    = 1'b1;
                    amem_waddr = {next_node, lvl_reg};
                    amem_wdata = {1'b1, AW'(0)};
                    p_next     = {1'b1, AW'(0)};
                    if (push_last) opcnt_next = next_node;
                    else lvl_next = lvl_reg + LW'(1);
                end
            end
            S_PWR: begin
                amem_we    = 1'b1;
                amem_waddr = {next_node, lvl_reg};
                amem_wdata = amem_q;
                p_next     = amem_q;
                if (push_last) opcnt_next = next_node;
                else lvl_next = lvl_reg + LW'(1);
            end
            S_RDB: begin
                y_next     = vq_top;
                vmem_raddr = x_reg;
                vmem_we    = 1'b1;
                vmem_wdata = {x_reg, AW'(0)};
            end
            S_DXA: begin
                dx_next    = vq_dep;
                vmem_raddr = y_reg;
            end
            S_DYB: dy_next = vq_dep;
            S_LIFT: begin
                side_next  = dy_reg > dx_reg;
                lvl_next   = lift_lvl;
                amem_raddr = {(dy_reg > dx_reg) ? y_reg : x_reg, lift_lvl};
                if (dx_reg == dy_reg) begin
                    lvl_next = LVL_TOP;
                    if (x_reg == y_reg) begin
                        val_next   = 16'(dx_reg);
                        opcnt_next = next_node;
                    end
                end
            end
            S_LSTP: begin
                if (side_reg) begin
                    y_next  = amem_q[AW-1:0];
                    dy_next = dy_reg - AW'(pw);
                end else begin
                    x_next  = amem_q[AW-1:0];
                    dx_next = dx_reg - AW'(pw);
                end
            end
            S_WALK: begin
                amem_raddr = {x_reg, lvl_reg};
                if (!walk_ok) lvl_next = lvl_reg - LW'(1);
            end
            S_WX: begin
                ax_next    = amem_q;
                amem_raddr = {y_reg, lvl_reg};
            end
            S_WY: begin
                if (ax_reg == amem_q) begin
                    if (lvl_reg == '0) begin
                        val_next   = 16'(dx_reg - AW'(1));
                        opcnt_next = next_node;
                    end else begin
                        lvl_next = lvl_reg - LW'(1);
                    end
                end else begin
                    x_next   = ax_reg[AW-1:0];
                    y_next   = amem_q[AW-1:0];
                    dx_next  = dx_reg - AW'(pw);
                    lvl_next = (lvl_reg == '0) ? LVL_TOP : lvl_reg - LW'(1);
                end
            end
            S_FIN: begin
                if (out_load) begin
                    out_valid_next       = 1'b1;
                    out_data_next.value  = (st_reg == ST_OK) ? val_reg : '0;
                    out_data_next.status = st_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            opcnt_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            opcnt_reg     <= opcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        va_reg       <= va_next;
        vb_reg       <= vb_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        lvl_reg      <= lvl_next;
        p_reg        <= p_next;
        ax_reg       <= ax_next;
        side_reg     <= side_next;
        st_reg       <= st_next;
        val_reg      <= val_next;
        zero_reg     <= vmem_raddr == '0;
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

@@ rtl/core/psle_ram.sv @@
// Generic simple dual-port RAM, one write port, one registered read port.
module psle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/psle_checker.sv @@
// Port-level checker for the persistent stack LCA engine, bound to the top.
`include "persistent_stack_lca_engine_macros.svh"

module psle_checker
    import psle_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input psle_in_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input psle_out_t m_data
);

    `PSLE_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result beat dropped or changed while stalled")
    `PSLE_ASSERT_NOW(a_err_zero, aclk, aresetn, m_valid && m_data.status != ST_OK, m_data.value == 16'd0, "error result carries nonzero value")
    `PSLE_ASSERT_RST(a_rst_quiet, aclk, !aresetn, !m_valid, "result valid right after reset")
    `PSLE_ASSERT_NEXT(a_busy, aclk, aresetn, s_valid && s_ready && s_data.cmd != CMD_NONE, !s_ready, "new beat taken while command in progress")

endmodule

bind persistent_stack_lca_engine psle_checker u_psle_checker (.*);

@@ tb/persistent_stack_lca_engine_checker.sv @@
// Checker for the persistent stack engine: it predicts each result and compares it.
module persistent_stack_lca_engine_checker
    import psle_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  psle_in_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  psle_out_t m_data,
    output int        fail_count,
    output int        pending,
    output int        newest_version,
    output int        results_seen
);
    localparam int VERSIONS = 65536;

    int unsigned ver_top   [VERSIONS];
    int unsigned node_par  [VERSIONS];
    int unsigned node_dep  [VERSIONS];
    int unsigned ops;
    psle_out_t   expected_q[$];

    function automatic int unsigned shared_depth(int unsigned x, int unsigned y);
        while (node_dep[x] > node_dep[y]) x = node_par[x];
        while (node_dep[y] > node_dep[x]) y = node_par[y];
        while (x != y) begin
            x = node_par[x];
            y = node_par[y];
        end
        return node_dep[x];
    endfunction

    task automatic predict(psle_in_t d);
        psle_out_t r;
        int unsigned nxt;
        r = '0;
        nxt = ops + 1;
        if (d.cmd == CMD_NONE) return;
        if (d.version_a > ops || (d.cmd == CMD_CMP && d.version_b > ops))
            r.status = ST_UNKNOWN;
        else if (nxt >= VERSIONS)
            r.status = ST_FULL;
        else if (d.cmd == CMD_POP && ver_top[d.version_a] == 0)
            r.status = ST_EMPTY;
        else if (d.cmd == CMD_PUSH) begin
            node_par[nxt] = ver_top[d.version_a];
            node_dep[nxt] = node_dep[ver_top[d.version_a]] + 1;
            ver_top[nxt] = nxt;
            ops = nxt;
            return;
        end else if (d.cmd == CMD_POP) begin
            r.value = 16'(ver_top[d.version_a]);
            ver_top[nxt] = node_par[ver_top[d.version_a]];
            ops = nxt;
        end else begin
            r.value = 16'(shared_depth(ver_top[d.version_a], ver_top[d.version_b]));
            ver_top[nxt] = ver_top[d.version_a];
            ops = nxt;
        end
        expected_q.push_back(r);
    endtask

    initial begin
        for (int i = 0; i < VERSIONS; i++) begin
            ver_top[i] = 0;
            node_par[i] = 0;
            node_dep[i] = 0;
        end
        ops = 0;
        fail_count = 0;
        results_seen = 0;
    end

    always @(posedge aclk) begin
        psle_out_t e;
        if (aresetn) begin
            if (s_valid && s_ready) predict(s_data);
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, actual value %0d status %0d",
                             $time, m_data.value, m_data.status);
                    fail_count++;
                end else begin
                    e = expected_q.pop_front();
                    if (e.value !== m_data.value) begin
                        $display("%0t: value mismatch, expected %0d, actual %0d",
                                 $time, e.value, m_data.value);
                        fail_count++;
                    end
                    if (e.status !== m_data.status) begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, e.status, m_data.status);
                        fail_count++;
                    end
                end
            end
        end
        pending <= expected_q.size();
        newest_version <= ops;
    end
endmodule

@@ tb/tb_persistent_stack_lca_engine.sv @@
// Top of the testbench: clock, reset, stimulus, output stalls and the verdict.
module tb_persistent_stack_lca_engine;
    import psle_pkg::*;

    localparam int LIMIT = 1000000;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    psle_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    psle_out_t m_data;
    int        fail_count, pending, newest_version, results_seen;
    int        cycles = 0;
    bit        quiet = 1'b0;
    int        n_push = 0, n_pop = 0, n_cmp = 0, n_other = 0;

    persistent_stack_lca_engine dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    persistent_stack_lca_engine_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending(pending),
        .newest_version(newest_version), .results_seen(results_seen)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result-side stalls
    initial begin
        int n;
        @(posedge aclk);
        forever begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 11);
                m_ready <= 1'b0;
            end else begin
                n = $urandom_range(1, 20);
                m_ready <= 1'b1;
            end
            repeat (n) @(posedge aclk);
        end
    end

    task automatic send(logic [1:0] c, logic [15:0] a, logic [15:0] b);
        psle_in_t d;
        d.cmd = c;
        d.version_a = a;
        d.version_b = b;
        s_valid <= 1'b1;
        s_data <= d;
        case (c)
            CMD_PUSH: n_push++;
            CMD_POP:  n_pop++;
            CMD_CMP:  n_cmp++;
            default:  n_other++;
        endcase
        do @(posedge aclk); while (!s_ready);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
    endtask

    function automatic logic [15:0] pick_version();
        int unsigned nv;
        nv = newest_version;
        if ($urandom_range(0, 1) == 0 && nv > 8)
            return 16'($urandom_range(nv - 8, nv));
        return 16'($urandom_range(0, nv));
    endfunction

    initial begin
        int w;
        logic [1:0] c;
        logic [15:0] a, b;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // directed part
        send(CMD_POP, 16'd0, 16'hFFFF);
        send(CMD_CMP, 16'd0, 16'd0);
        send(CMD_PUSH, 16'hFFFF, 16'd0);
        send(CMD_POP, 16'hFFFF, 16'd0);
        send(CMD_CMP, 16'hFFFF, 16'd0);
        send(CMD_CMP, 16'd0, 16'hFFFF);
        send(CMD_NONE, 16'hFFFF, 16'hFFFF);
        send(CMD_NONE, 16'd0, 16'd0);
        send(CMD_PUSH, 16'd0, 16'hFFFF);
        send(CMD_PUSH, 16'd1, 16'd0);
        send(CMD_PUSH, 16'd2, 16'd0);
        send(CMD_PUSH, 16'd1, 16'd0);
        send(CMD_CMP, 16'd3, 16'd4);
        send(CMD_CMP, 16'd3, 16'd3);
        send(CMD_CMP, 16'd0, 16'd3);
        send(CMD_POP, 16'd3, 16'd0);
        send(CMD_POP, 16'd0, 16'd0);
        send(CMD_CMP, 16'd7, 16'd2);
        send(CMD_PUSH, 16'd8, 16'd0);
        send(CMD_CMP, 16'd9, 16'd10);
        // random part, no idling in the last stretch
        for (int i = 0; i < 930; i++) begin
            if (i == 800) quiet = 1'b1;
            w = $urandom_range(0, 99);
            a = pick_version();
            b = pick_version();
            if (w < 45) c = CMD_PUSH;
            else if (w < 68) c = CMD_POP;
            else if (w < 92) c = CMD_CMP;
            else if (w < 95) begin
                c = 2'($urandom_range(0, 2));
                if ($urandom_range(0, 1)) a = 16'($urandom);
                else b = 16'($urandom);
            end else if (w < 97) begin
                c = CMD_NONE;
                a = 16'($urandom);
                b = 16'($urandom);
            end else begin
                c = CMD_POP;
                a = 16'd0;
            end
            if (c != CMD_CMP && $urandom_range(0, 1)) b = 16'($urandom);
            send(c, a, b);
        end
        s_valid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        $display("Sent %0d push, %0d pop, %0d compare and %0d unused-code beats",
                 n_push, n_pop, n_cmp, n_other);
        $display("Checked %0d result beats; newest version %0d", results_seen, newest_version);
        if (fail_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/psle_pkg.sv
rtl/core/psle_ram.sv
rtl/core/persistent_stack_lca_engine.sv
rtl/core/psle_checker.sv
tb/persistent_stack_lca_engine_checker.sv
tb/tb_persistent_stack_lca_engine.sv
